[rtl/core/sorted_multiset_rank_engine_unit_assert.svh]
// Assertion macros for the checker file of the rank engine.
// Depends on nothing; included by the checker module file.
`ifndef SORTED_MULTISET_RANK_ENGINE_UNIT_ASSERT_SVH
`define SORTED_MULTISET_RANK_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMRE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/smre_pkg.sv]
// Shared types and codes of the sorted multiset rank engine.
// Depends on nothing; used by every module of the block.
package smre_pkg;

   localparam int CAPACITY_DEF = 256;

   localparam logic [2:0] ACT_INSERT = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_RANK   = 3'd2;
   localparam logic [2:0] ACT_KTH    = 3'd3;
   localparam logic [2:0] ACT_PRED   = 3'd4;
   localparam logic [2:0] ACT_SUCC   = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0] answer;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic shift_in;
      logic shift_out;
   } cell_ctl_type;

   typedef struct packed {
      logic below;
      logic not_above;
      logic pred_hit;
      logic succ_hit;
      logic kth_hit;
      logic eq_hit;
   } cell_flag_type;

   typedef struct packed {
      logic pred_any;
      logic succ_any;
      logic kth_any;
      logic eq_any;
   } red_hit_type;

endpackage

[rtl/core/smre_cell.sv]
// One storage cell of the sorted chain: holds one value and its compare flags.
// Depends on smre_pkg; instantiated in a row by the top level.
module smre_cell
   import smre_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int IDX = 0,
   localparam int CntW = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [CntW-1:0]    occupancy,
   input  logic signed [31:0] operand,
   input  logic signed [31:0] left_value,
   input  logic signed [31:0] right_value,
   input  logic               left_below,
   input  logic               left_not_above,
   input  logic               right_below,
   output logic signed [31:0] value,
   output cell_flag_type      flags
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, below_ff, not_above_ff, kth_ff;
   logic               valid_now;

   assign valid_now = CntW'(IDX) < occupancy;

   always_comb begin
      value_in = value_ff;
      if (ctl.shift_in && !below_ff) begin
         value_in = left_below ? operand : left_value;
      end else if (ctl.shift_out && !below_ff) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (ctl.capture) begin
         valid_ff     <= valid_now;
         below_ff     <= valid_now && (value_ff < operand);
         not_above_ff <= valid_now && (value_ff <= operand);
         kth_ff       <= valid_now && (operand == 32'(IDX + 1));
      end
   end

   assign value           = value_ff;
   assign flags.below     = below_ff;
   assign flags.not_above = not_above_ff;
   assign flags.pred_hit  = below_ff && !right_below;
   assign flags.succ_hit  = valid_ff && !not_above_ff && left_not_above;
   assign flags.kth_hit   = kth_ff;
   assign flags.eq_hit    = not_above_ff && !below_ff;

endmodule

[rtl/core/smre_reduce.sv]
// Reduction over the cell row: selects the flagged values and encodes the rank.
// Depends on smre_pkg; takes the registered flags of every cell.
module smre_reduce
   import smre_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CntW = $clog2(CAPACITY + 1)
) (
   input  cell_flag_type      flags [CAPACITY],
   input  logic signed [31:0] values [CAPACITY],
   output logic [CntW-1:0]    rank_count,
   output logic signed [31:0] pred_value,
   output logic signed [31:0] succ_value,
   output logic signed [31:0] kth_value,
   output red_hit_type        hits
);

   always_comb begin
      rank_count = '0;
      pred_value = '0;
      succ_value = '0;
      kth_value  = '0;
      hits       = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (flags[i].pred_hit) begin
            rank_count = rank_count | CntW'(i + 1);
            pred_value = pred_value | values[i];
         end
         if (flags[i].succ_hit) begin
            succ_value = succ_value | values[i];
         end
         if (flags[i].kth_hit) begin
            kth_value = kth_value | values[i];
         end
         hits.pred_any = hits.pred_any | flags[i].pred_hit;
         hits.succ_any = hits.succ_any | flags[i].succ_hit;
         hits.kth_any  = hits.kth_any | flags[i].kth_hit;
         hits.eq_any   = hits.eq_any | flags[i].eq_hit;
      end
   end

endmodule

[rtl/core/sorted_multiset_rank_engine_unit.sv]
// Timing: an accepted beat passes the evaluate and response states; its result is
// registered with the strobe. The cell row compares in the evaluate state and the
// reduction plus the store shift take the response state, during which the next beat is taken.
// Reset: synchronous, clears the occupancy count and control; cell contents stay
// undefined until written. The result has no back-pressure.
module sorted_multiset_rank_engine_unit
   import smre_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CntW = $clog2(CAPACITY + 1);

   localparam logic [1:0] STATE_IDLE = 2'd0;
   localparam logic [1:0] STATE_EVAL = 2'd1;
   localparam logic [1:0] STATE_RESP = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CntW-1:0]    occupancy_ff, occupancy_in;
   req_type            req_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff;
   logic               accept;
   logic               full;
   cell_ctl_type       ctl;
   cell_flag_type      flags  [CAPACITY];
   logic signed [31:0] values [CAPACITY];
   logic [CntW-1:0]    rank_count;
   logic signed [31:0] pred_value, succ_value, kth_value;
   red_hit_type        hits;

   assign busy   = (state_ff == STATE_EVAL);
   assign accept = start && !busy;
   assign full   = (occupancy_ff == CntW'(CAPACITY));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (accept) state_in = STATE_EVAL;
         end
         STATE_EVAL: begin
            state_in = STATE_RESP;
         end
         STATE_RESP: begin
            state_in = accept ? STATE_EVAL : STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.capture   = (state_ff == STATE_EVAL);
      ctl.shift_in  = (state_ff == STATE_RESP) && (req_ff.action == ACT_INSERT) && !full;
      ctl.shift_out = (state_ff == STATE_RESP) && (req_ff.action == ACT_DELETE) && hits.eq_any;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_value, right_value;
      logic               left_below, left_not_above, right_below;

      if (i == 0) begin : g_first
         assign left_value     = req_ff.operand;
         assign left_below     = 1'b1;
         assign left_not_above = 1'b1;
      end else begin : g_inner_left
         assign left_value     = values[i-1];
         assign left_below     = flags[i-1].below;
         assign left_not_above = flags[i-1].not_above;
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
         assign right_below = 1'b0;
      end else begin : g_inner_right
         assign right_value = values[i+1];
         assign right_below = flags[i+1].below;
      end

      smre_cell #(
         .CAPACITY (CAPACITY),
         .IDX      (i)
      ) u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .occupancy      (occupancy_ff),
         .operand        (req_ff.operand),
         .left_value     (left_value),
         .right_value    (right_value),
         .left_below     (left_below),
         .left_not_above (left_not_above),
         .right_below    (right_below),
         .value          (values[i]),
         .flags          (flags[i])
      );
   end

   smre_reduce #(
      .CAPACITY (CAPACITY)
   ) u_reduce (
      .flags      (flags),
      .values     (values),
      .rank_count (rank_count),
      .pred_value (pred_value),
      .succ_value (succ_value),
      .kth_value  (kth_value),
      .hits       (hits)
   );

   always_comb begin
      rsp_in.answer = '0;
      rsp_in.status = ST_OK;
      case (req_ff.action)
         ACT_INSERT: begin
            if (full) rsp_in.status = ST_FULL;
         end
         ACT_DELETE: begin
            if (!hits.eq_any) rsp_in.status = ST_MISS;
         end
         ACT_RANK: begin
            rsp_in.answer = 32'(rank_count) + 32'd1;
         end
         ACT_KTH: begin
            if (hits.kth_any) rsp_in.answer = kth_value;
            else rsp_in.status = ST_MISS;
         end
         ACT_PRED: begin
            if (hits.pred_any) rsp_in.answer = pred_value;
            else rsp_in.status = ST_MISS;
         end
         ACT_SUCC: begin
            if (hits.succ_any) rsp_in.answer = succ_value;
            else rsp_in.status = ST_MISS;
         end
         default: begin
            rsp_in.status = ST_MISS;
         end
      endcase
   end

   always_comb begin
      occupancy_in = occupancy_ff;
      if (ctl.shift_in) begin
         occupancy_in = occupancy_ff + CntW'(1);
      end else if (ctl.shift_out) begin
         occupancy_in = occupancy_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         occupancy_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occupancy_ff  <= occupancy_in;
         rsp_strobe_ff <= (state_ff == STATE_RESP);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_item;
      if (state_ff == STATE_RESP) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

[rtl/core/smre_checker.sv]
// Port-level checker for the rank engine, bound to the top level.
// Depends on smre_pkg and the assertion macro header.
`include "sorted_multiset_rank_engine_unit_assert.svh"

module smre_checker
   import smre_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   `SMRE_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy, "accepted beat did not raise busy")
   `SMRE_ASSERT_SAME(a_result_follows, clock, reset, start && !busy, ##3 rsp_strobe, "result beat missing three cycles after accept")
   `SMRE_ASSERT_SAME(a_status_legal, clock, reset, rsp_strobe, rsp_item.status == ST_OK || rsp_item.status == ST_MISS || rsp_item.status == ST_FULL, "illegal status code")
   `SMRE_ASSERT_SAME(a_error_answer_zero, clock, reset, rsp_strobe && rsp_item.status != ST_OK, rsp_item.answer == 32'sd0, "nonzero answer with error status")

endmodule

bind sorted_multiset_rank_engine_unit smre_checker u_smre_checker (.*);

[test/tb_top.sv]
// Self-checking bench for the sorted multiset rank engine: directed corner beats,
// a fill to capacity and drain, then a long random mix, all scored against a shadow set.
// Depends on smre_pkg and sorted_multiset_rank_engine_unit only.
`timescale 1ns / 1ps

module tb_top;
   import smre_pkg::*;

   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int         INT_LOW      = 32'sh8000_0000;
   localparam int         INT_HIGH     = 32'sh7FFF_FFFF;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   int      shadow_set[$];
   rsp_type pending_replies[$];
   int      error_count;
   int      beats_sent;
   int      replies_checked;
   int      peak_fill;
   int      full_seen;
   int      miss_seen;
   bit      quiet_sender;

   sorted_multiset_rank_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int count_below(int v);
      int n;
      n = 0;
      foreach (shadow_set[i]) if (shadow_set[i] < v) n++;
      return n;
   endfunction

   function automatic int count_not_above(int v);
      int n;
      n = 0;
      foreach (shadow_set[i]) if (shadow_set[i] <= v) n++;
      return n;
   endfunction

   // Applies one beat to the shadow set and returns the reply the engine should give.
   function automatic rsp_type apply_to_shadow(req_type beat);
      rsp_type reply;
      int      v;
      int      pos;
      v = beat.operand;
      reply.answer = '0;
      reply.status = ST_OK;
      case (beat.action)
         ACT_INSERT: begin
            if (shadow_set.size() >= CAPACITY_DEF) begin
               reply.status = ST_FULL;
            end else begin
               shadow_set.insert(count_below(v), v);
            end
         end
         ACT_DELETE: begin
            pos = count_below(v);
            if (pos >= shadow_set.size() || shadow_set[pos] != v) begin
               reply.status = ST_MISS;
            end else begin
               shadow_set.delete(pos);
            end
         end
         ACT_RANK: begin
            reply.answer = count_below(v) + 1;
         end
         ACT_KTH: begin
            if (v < 1 || v > shadow_set.size()) begin
               reply.status = ST_MISS;
            end else begin
               reply.answer = shadow_set[v - 1];
            end
         end
         ACT_PRED: begin
            pos = count_below(v);
            if (pos == 0) begin
               reply.status = ST_MISS;
            end else begin
               reply.answer = shadow_set[pos - 1];
            end
         end
         ACT_SUCC: begin
            pos = count_not_above(v);
            if (pos >= shadow_set.size()) begin
               reply.status = ST_MISS;
            end else begin
               reply.answer = shadow_set[pos];
            end
         end
         default: begin
            reply.status = ST_MISS;
         end
      endcase
      if (reply.status == ST_FULL) full_seen++;
      if (reply.status == ST_MISS) miss_seen++;
      if (shadow_set.size() > peak_fill) peak_fill = shadow_set.size();
      return reply;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic [2:0] action, input int operand);
      int      gap;
      req_type beat;
      beat.action  = action;
      beat.operand = operand;
      gap = quiet_sender ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_item = beat;
      do @(posedge clock); while (busy);
      pending_replies.insert(pending_replies.size(), apply_to_shadow(beat));
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic int pick_value();
      int pool[6];
      int sel;
      pool = '{INT_LOW, INT_HIGH, INT_LOW + 1, INT_HIGH - 1, 0, -1};
      sel = $urandom_range(0, 9);
      if (sel <= 3 && shadow_set.size() > 0) begin
         return shadow_set[$urandom_range(0, shadow_set.size() - 1)];
      end else if (sel == 4 && shadow_set.size() > 0) begin
         return shadow_set[$urandom_range(0, shadow_set.size() - 1)]
                + int'($urandom_range(0, 2)) - 1;
      end else if (sel <= 6) begin
         return int'($urandom_range(0, 16)) - 8;
      end else if (sel == 7) begin
         return pool[$urandom_range(0, 5)];
      end
      return int'($urandom);
   endfunction

   function automatic int pick_position();
      if ($urandom_range(0, 4) == 0) return pick_value();
      return $urandom_range(0, shadow_set.size() + 1);
   endfunction

   task automatic test_edge_cases();
      send_beat(ACT_RANK, 5);
      send_beat(ACT_KTH, 1);
      send_beat(ACT_PRED, 0);
      send_beat(ACT_SUCC, 0);
      send_beat(ACT_DELETE, 7);
      send_beat(ACT_SPARE_LO, 3);
      send_beat(ACT_SPARE_HI, -1);
      send_beat(ACT_INSERT, INT_LOW);
      send_beat(ACT_INSERT, INT_HIGH);
      send_beat(ACT_INSERT, 0);
      send_beat(ACT_INSERT, 0);
      send_beat(ACT_INSERT, -1);
      send_beat(ACT_RANK, INT_LOW);
      send_beat(ACT_RANK, INT_HIGH);
      send_beat(ACT_KTH, 0);
      send_beat(ACT_KTH, -1);
      send_beat(ACT_KTH, 1);
      send_beat(ACT_KTH, 5);
      send_beat(ACT_KTH, 6);
      send_beat(ACT_KTH, INT_HIGH);
      send_beat(ACT_KTH, INT_LOW);
      send_beat(ACT_PRED, INT_LOW);
      send_beat(ACT_PRED, 0);
      send_beat(ACT_SUCC, INT_HIGH);
      send_beat(ACT_SUCC, 0);
      send_beat(ACT_DELETE, 0);
      send_beat(ACT_DELETE, 5);
   endtask

   task automatic test_fill_to_capacity();
      quiet_sender = 1'b1;
      while (shadow_set.size() < CAPACITY_DEF) begin
         if (shadow_set.size() == CAPACITY_DEF / 2) quiet_sender = 1'b0;
         send_beat(ACT_INSERT, pick_value());
      end
      repeat (4) send_beat(ACT_INSERT, pick_value());
      send_beat(ACT_KTH, CAPACITY_DEF);
      send_beat(ACT_KTH, CAPACITY_DEF + 1);
      send_beat(ACT_RANK, INT_HIGH);
      send_beat(ACT_PRED, INT_HIGH);
      send_beat(ACT_SUCC, INT_LOW);
      send_beat(ACT_DELETE, shadow_set[CAPACITY_DEF - 1]);
      send_beat(ACT_INSERT, INT_HIGH);
      send_beat(ACT_INSERT, INT_LOW);
   endtask

   task automatic test_drain();
      while (shadow_set.size() > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            send_beat(ACT_DELETE, int'($urandom));
         end else begin
            send_beat(ACT_DELETE, shadow_set[$urandom_range(0, shadow_set.size() - 1)]);
         end
      end
      send_beat(ACT_RANK, INT_HIGH);
      send_beat(ACT_KTH, 1);
      send_beat(ACT_PRED, INT_HIGH);
      send_beat(ACT_SUCC, INT_LOW);
   endtask

   task automatic test_random_mix(input int count);
      bit growing;
      int roll;
      growing = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (n % 200 == 0) growing = ~growing;
         if (n % 100 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < (growing ? 40 : 20)) begin
            send_beat(ACT_INSERT, pick_value());
         end else if (roll < 60) begin
            send_beat(ACT_DELETE, pick_value());
         end else if (roll < 70) begin
            send_beat(ACT_RANK, pick_value());
         end else if (roll < 80) begin
            send_beat(ACT_KTH, pick_position());
         end else if (roll < 88) begin
            send_beat(ACT_PRED, pick_value());
         end else if (roll < 96) begin
            send_beat(ACT_SUCC, pick_value());
         end else begin
            send_beat(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), pick_value());
         end
      end
      quiet_sender = 1'b0;
   endtask

   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: reply with no beat outstanding, answer %0d status %0d",
                     $time, rsp_item.answer, rsp_item.status);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            replies_checked++;
            if (rsp_item.answer !== want.answer) begin
               $display("%0t: answer mismatch, expected %0d, actual %0d",
                        $time, want.answer, rsp_item.answer);
               error_count++;
            end
            if (rsp_item.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_item.status);
               error_count++;
            end
         end
      end
   end

   initial begin
      int waited;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      quiet_sender = 1'b0;
      error_count  = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_edge_cases();
      test_fill_to_capacity();
      test_drain();
      test_random_mix(1050);
      start = 1'b0;

      waited = 0;
      while (pending_replies.size() > 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_replies.size() > 0) begin
         $display("%0t: %0d expected replies never arrived", $time, pending_replies.size());
         error_count++;
      end

      $display("Sent %0d beats and checked %0d replies; peak fill %0d of %0d.",
               beats_sent, replies_checked, peak_fill, CAPACITY_DEF);
      $display("Store-full replies %0d, not-found or out-of-range replies %0d.",
               full_seen, miss_seen);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
